FILE: rtl/mcrts_pkg.sv
// shared types, codes and helper functions for the caller receive training sequencer
// no dependencies; used by every module under rtl
`default_nettype none

package mcrts_pkg;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRAIN_LEN   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESYNC_LEN  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B1_LEN      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_POLICY = 2'd3;

   localparam logic [15:0] TRAIN_LEN_RESET  = 16'd256;
   localparam logic [15:0] RESYNC_LEN_RESET = 16'd256;
   localparam logic [15:0] B1_LEN_RESET     = 16'd16;

   // rate policies
   localparam logic [1:0] POL_NEGOTIATED = 2'd0;
   localparam logic [1:0] POL_VOICE      = 2'd1;
   localparam logic [1:0] POL_FAX        = 2'd2;
   localparam logic [1:0] POL_FIXED      = 2'd3;

   // detector modes
   localparam logic [1:0] DET_OFF     = 2'd0;
   localparam logic [1:0] DET_ENERGY  = 2'd1;
   localparam logic [1:0] DET_CORR    = 2'd2;
   localparam logic [1:0] DET_SILENCE = 2'd3;

   // equalizer modes
   localparam logic [1:0] EQU_OFF         = 2'd0;
   localparam logic [1:0] EQU_INIT        = 2'd1;
   localparam logic [1:0] EQU_INIT_RESYNC = 2'd2;
   localparam logic [1:0] EQU_TRACK       = 2'd3;

   // rate detector modes
   localparam logic [1:0] RDET_OFF   = 2'd0;
   localparam logic [1:0] RDET_LOOKR = 2'd1;
   localparam logic [1:0] RDET_LOOKE = 2'd2;

   // symbol modes
   localparam logic [2:0] SYM_TRAIN  = 3'd0;
   localparam logic [2:0] SYM_QPSK   = 3'd1;
   localparam logic [2:0] SYM_QAM16  = 3'd2;
   localparam logic [2:0] SYM_QAM32  = 3'd3;
   localparam logic [2:0] SYM_QAM64  = 3'd4;
   localparam logic [2:0] SYM_QAM128 = 3'd5;

   // detected rate codes
   localparam logic [2:0] RCODE_QAM16  = 3'd0;
   localparam logic [2:0] RCODE_QAM32  = 3'd1;
   localparam logic [2:0] RCODE_QAM64  = 3'd2;
   localparam logic [2:0] RCODE_QAM128 = 3'd3;

   localparam logic [13:0] RATE_NONE  = 14'd0;
   localparam logic [13:0] RATE_7200  = 14'd7200;
   localparam logic [13:0] RATE_9600  = 14'd9600;
   localparam logic [13:0] RATE_12000 = 14'd12000;
   localparam logic [13:0] RATE_14400 = 14'd14400;

   // action strobes
   localparam logic [6:0] ACT_NONE       = 7'h00;
   localparam logic [6:0] ACT_SET_RATE   = 7'h01;
   localparam logic [6:0] ACT_TIMING_INIT = 7'h02;
   localparam logic [6:0] ACT_RATES_INIT = 7'h04;
   localparam logic [6:0] ACT_EQU_INIT   = 7'h08;
   localparam logic [6:0] ACT_DET_CLEAR  = 7'h10;
   localparam logic [6:0] ACT_RETRAIN    = 7'h20;
   localparam logic [6:0] ACT_DATA_START = 7'h40;

   // receive phases, one-hot
   typedef enum logic [17:0] {
      PH_ANSWER  = 18'd1,
      PH_AC1     = 18'd2,
      PH_CA      = 18'd4,
      PH_AC2     = 18'd8,
      PH_SILENCE = 18'd16,
      PH_S1      = 18'd32,
      PH_SBAR1   = 18'd64,
      PH_TRN1    = 18'd128,
      PH_R1      = 18'd256,
      PH_WAIT    = 18'd512,
      PH_S2      = 18'd1024,
      PH_SBAR2   = 18'd2048,
      PH_TRN2    = 18'd4096,
      PH_R3      = 18'd8192,
      PH_E       = 18'd16384,
      PH_B1      = 18'd32768,
      PH_START   = 18'd65536,
      PH_DATA    = 18'd131072
   } phase_type;

   typedef struct packed {
      logic       det_flag;
      logic       tx_handoff;
      logic       idle_seen;
      logic       retrain_req;
      logic       equ_init_incomplete;
      logic [2:0] detected_rate;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  phase;
      logic        det_flag_out;
      logic [1:0]  detector_mode;
      logic        spectrum_select;
      logic        agc_enable;
      logic        timing_enable;
      logic [1:0]  equalizer_mode;
      logic [1:0]  rate_detector_mode;
      logic [2:0]  symbol_mode;
      logic [13:0] line_rate;
      logic        rate_found;
      logic [6:0]  actions;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] train_to_decision_len;
      logic [15:0] resync_len;
      logic [15:0] b1_len;
      logic [1:0]  rate_policy;
   } csr_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  detector_mode;
      logic        spectrum;
      logic        agc;
      logic        timing;
      logic [1:0]  equalizer;
      logic [1:0]  rate_det;
      logic [2:0]  symbol_mode;
      logic [13:0] line_rate;
      logic [2:0]  rate_code;
      logic        rate_found;
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]  symbol_mode;
      logic [13:0] line_rate;
   } rate_sel_type;

   localparam ctrl_state_type STATE_RESET = '{
      phase:         PH_ANSWER,
      detector_mode: DET_OFF,
      spectrum:      1'b0,
      agc:           1'b0,
      timing:        1'b0,
      equalizer:     EQU_OFF,
      rate_det:      RDET_OFF,
      symbol_mode:   SYM_TRAIN,
      line_rate:     RATE_NONE,
      rate_code:     RCODE_QAM16,
      rate_found:    1'b0
   };

   function automatic rate_sel_type choose_rate(input logic [1:0] policy,
                                                input logic [2:0] code);
      rate_sel_type sel;
      sel = '{symbol_mode: SYM_TRAIN, line_rate: RATE_NONE};
      case (policy)
         POL_NEGOTIATED: begin
            case (code)
               RCODE_QAM16:  sel = '{symbol_mode: SYM_QAM16,  line_rate: RATE_7200};
               RCODE_QAM32:  sel = '{symbol_mode: SYM_QAM32,  line_rate: RATE_9600};
               RCODE_QAM64:  sel = '{symbol_mode: SYM_QAM64,  line_rate: RATE_12000};
               RCODE_QAM128: sel = '{symbol_mode: SYM_QAM128, line_rate: RATE_14400};
               default:      sel = '{symbol_mode: SYM_TRAIN,  line_rate: RATE_NONE};
            endcase
         end
         POL_VOICE: sel = '{symbol_mode: SYM_QAM32, line_rate: RATE_9600};
         POL_FAX: begin
            if (code == RCODE_QAM128) begin
               sel = '{symbol_mode: SYM_QAM128, line_rate: RATE_14400};
            end else begin
               sel = '{symbol_mode: SYM_QAM32, line_rate: RATE_9600};
            end
         end
         default: sel = '{symbol_mode: SYM_QAM64, line_rate: RATE_12000};
      endcase
      return sel;
   endfunction

   function automatic logic [4:0] phase_code(input phase_type p);
      logic [4:0] code;
      unique case (p)
         PH_ANSWER:  code = 5'd0;
         PH_AC1:     code = 5'd1;
         PH_CA:      code = 5'd2;
         PH_AC2:     code = 5'd3;
         PH_SILENCE: code = 5'd4;
         PH_S1:      code = 5'd5;
         PH_SBAR1:   code = 5'd6;
         PH_TRN1:    code = 5'd7;
         PH_R1:      code = 5'd8;
         PH_WAIT:    code = 5'd9;
         PH_S2:      code = 5'd10;
         PH_SBAR2:   code = 5'd11;
         PH_TRN2:    code = 5'd12;
         PH_R3:      code = 5'd13;
         PH_E:       code = 5'd14;
         PH_B1:      code = 5'd15;
         PH_START:   code = 5'd16;
         PH_DATA:    code = 5'd17;
         default:    code = 5'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mcrts_csr.sv
// configuration registers: training, resync and B1 lengths and rate policy
// depends on mcrts_pkg
`default_nettype none

module mcrts_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [mcrts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mcrts_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output mcrts_pkg::csr_type                         csr
);

   mcrts_pkg::csr_type csr_ff;
   mcrts_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mcrts_pkg::CSR_TRAIN_LEN:   csr_in.train_to_decision_len = csr_wdata;
            mcrts_pkg::CSR_RESYNC_LEN:  csr_in.resync_len = csr_wdata;
            mcrts_pkg::CSR_B1_LEN:      csr_in.b1_len = csr_wdata;
            mcrts_pkg::CSR_RATE_POLICY: csr_in.rate_policy = csr_wdata[1:0];
            default:                    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.train_to_decision_len <= mcrts_pkg::TRAIN_LEN_RESET;
         csr_ff.resync_len            <= mcrts_pkg::RESYNC_LEN_RESET;
         csr_ff.b1_len                <= mcrts_pkg::B1_LEN_RESET;
         csr_ff.rate_policy           <= mcrts_pkg::POL_NEGOTIATED;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

FILE: rtl/mcrts_step.sv
// next-state and result logic for one word: phase transitions, counter, rate choice
// depends on mcrts_pkg
`default_nettype none

module mcrts_step #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire mcrts_pkg::ctrl_state_type cur,
   input  wire logic [COUNT_WIDTH-1:0]    count_cur,
   input  wire mcrts_pkg::req_word_type   word,
   input  wire mcrts_pkg::csr_type        csr,
   output mcrts_pkg::ctrl_state_type      nxt,
   output logic [COUNT_WIDTH-1:0]         count_nxt,
   output mcrts_pkg::rsp_word_type        result
);

   logic [31:0]            train_ext;
   logic [31:0]            resync_ext;
   logic [31:0]            b1_ext;
   logic [COUNT_WIDTH-1:0] train_len;
   logic [COUNT_WIDTH-1:0] resync_len;
   logic [COUNT_WIDTH-1:0] b1_len;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   det_out;
   logic [6:0]             act;
   mcrts_pkg::rate_sel_type rate_sel;

   // lengths cut or zero-extended to the counter width
   assign train_ext  = {16'd0, csr.train_to_decision_len};
   assign resync_ext = {16'd0, csr.resync_len};
   assign b1_ext     = {16'd0, csr.b1_len};
   assign train_len  = train_ext[COUNT_WIDTH-1:0];
   assign resync_len = resync_ext[COUNT_WIDTH-1:0];
   assign b1_len     = b1_ext[COUNT_WIDTH-1:0];
   assign count_inc  = count_cur + COUNT_WIDTH'(1);
   assign rate_sel   = mcrts_pkg::choose_rate(csr.rate_policy, cur.rate_code);

   always_comb begin
      nxt       = cur;
      count_nxt = count_cur;
      det_out   = word.det_flag;
      act       = mcrts_pkg::ACT_NONE;
      unique case (cur.phase)
         mcrts_pkg::PH_ANSWER: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_AC1;
               nxt.detector_mode = mcrts_pkg::DET_ENERGY;
               nxt.spectrum      = 1'b0;
            end
         end
         mcrts_pkg::PH_AC1: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_CA;
               nxt.detector_mode = mcrts_pkg::DET_CORR;
               det_out           = 1'b0;
            end
         end
         mcrts_pkg::PH_CA: begin
            if (word.det_flag) begin
               nxt.phase = mcrts_pkg::PH_AC2;
            end
         end
         mcrts_pkg::PH_AC2: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_SILENCE;
               nxt.detector_mode = mcrts_pkg::DET_SILENCE;
            end
         end
         mcrts_pkg::PH_SILENCE: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_S1;
               nxt.detector_mode = mcrts_pkg::DET_ENERGY;
               nxt.spectrum      = 1'b1;
               det_out           = 1'b0;
            end
         end
         mcrts_pkg::PH_S1: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_SBAR1;
               nxt.detector_mode = mcrts_pkg::DET_CORR;
               nxt.agc           = 1'b1;
               det_out           = 1'b0;
               count_nxt         = '0;
            end
         end
         mcrts_pkg::PH_SBAR1: begin
            count_nxt = count_inc;
            if (count_inc == COUNT_WIDTH'(2)) begin
               nxt.timing = 1'b1;
            end
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_TRN1;
               nxt.detector_mode = mcrts_pkg::DET_OFF;
               nxt.equalizer     = word.equ_init_incomplete ? mcrts_pkg::EQU_OFF
                                                            : mcrts_pkg::EQU_INIT;
               count_nxt         = '0;
               nxt.symbol_mode   = mcrts_pkg::SYM_TRAIN;
               act               = mcrts_pkg::ACT_SET_RATE | mcrts_pkg::ACT_EQU_INIT;
               det_out           = 1'b0;
            end
         end
         mcrts_pkg::PH_TRN1: begin
            if (cur.equalizer == mcrts_pkg::EQU_OFF) begin
               nxt.equalizer = mcrts_pkg::EQU_INIT;
            end
            count_nxt = count_inc;
            if (count_cur == train_len) begin
               nxt.symbol_mode = mcrts_pkg::SYM_QPSK;
               act             = mcrts_pkg::ACT_SET_RATE;
               nxt.phase       = mcrts_pkg::PH_R1;
               nxt.rate_det    = mcrts_pkg::RDET_LOOKR;
            end
         end
         mcrts_pkg::PH_R1: begin
            if (word.det_flag) begin
               nxt.phase     = mcrts_pkg::PH_WAIT;
               nxt.equalizer = mcrts_pkg::EQU_OFF;
               nxt.timing    = 1'b0;
               nxt.rate_det  = mcrts_pkg::RDET_OFF;
            end
         end
         mcrts_pkg::PH_WAIT: begin
            if (word.tx_handoff) begin
               nxt.phase         = mcrts_pkg::PH_S2;
               nxt.detector_mode = mcrts_pkg::DET_ENERGY;
            end
         end
         mcrts_pkg::PH_S2: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_SBAR2;
               nxt.detector_mode = mcrts_pkg::DET_CORR;
               det_out           = 1'b0;
               nxt.timing        = 1'b1;
               act               = mcrts_pkg::ACT_TIMING_INIT;
            end
         end
         mcrts_pkg::PH_SBAR2: begin
            if (word.det_flag) begin
               nxt.phase         = mcrts_pkg::PH_TRN2;
               nxt.detector_mode = mcrts_pkg::DET_OFF;
               nxt.equalizer     = word.equ_init_incomplete ? mcrts_pkg::EQU_OFF
                                                            : mcrts_pkg::EQU_INIT_RESYNC;
               act               = mcrts_pkg::ACT_EQU_INIT;
               count_nxt         = '0;
               det_out           = 1'b0;
            end
         end
         mcrts_pkg::PH_TRN2: begin
            count_nxt = count_inc;
            if (cur.equalizer == mcrts_pkg::EQU_OFF) begin
               nxt.equalizer = mcrts_pkg::EQU_INIT_RESYNC;
            end
            if (count_inc == resync_len) begin
               nxt.phase      = mcrts_pkg::PH_R3;
               nxt.rate_found = 1'b0;
               nxt.equalizer  = mcrts_pkg::EQU_TRACK;
               act            = mcrts_pkg::ACT_EQU_INIT | mcrts_pkg::ACT_RATES_INIT;
               nxt.rate_det   = mcrts_pkg::RDET_LOOKR;
            end
         end
         mcrts_pkg::PH_R3: begin
            if (word.det_flag) begin
               nxt.phase      = mcrts_pkg::PH_E;
               nxt.rate_det   = mcrts_pkg::RDET_LOOKE;
               nxt.rate_code  = word.detected_rate;
               nxt.rate_found = 1'b1;
            end
         end
         mcrts_pkg::PH_E: begin
            if (word.det_flag) begin
               nxt.phase       = mcrts_pkg::PH_B1;
               nxt.rate_det    = mcrts_pkg::RDET_OFF;
               count_nxt       = '0;
               nxt.symbol_mode = rate_sel.symbol_mode;
               nxt.line_rate   = rate_sel.line_rate;
               act             = mcrts_pkg::ACT_SET_RATE;
            end
         end
         mcrts_pkg::PH_B1: begin
            count_nxt = count_inc;
            if (count_inc == b1_len) begin
               act       = mcrts_pkg::ACT_DATA_START;
               nxt.phase = mcrts_pkg::PH_START;
            end
         end
         mcrts_pkg::PH_START: begin
            if (word.idle_seen) begin
               nxt.phase         = mcrts_pkg::PH_DATA;
               nxt.detector_mode = mcrts_pkg::DET_ENERGY;
               nxt.spectrum      = 1'b0;
               act               = mcrts_pkg::ACT_DET_CLEAR;
            end
         end
         mcrts_pkg::PH_DATA: begin
            if (word.retrain_req) begin
               nxt               = mcrts_pkg::STATE_RESET;
               count_nxt         = '0;
               nxt.phase         = mcrts_pkg::PH_AC1;
               nxt.detector_mode = mcrts_pkg::DET_ENERGY;
               nxt.spectrum      = 1'b0;
               act               = mcrts_pkg::ACT_RETRAIN;
            end
         end
         default: begin
            nxt       = cur;
            count_nxt = count_cur;
         end
      endcase
   end

   always_comb begin
      result.phase              = mcrts_pkg::phase_code(nxt.phase);
      result.det_flag_out       = det_out;
      result.detector_mode      = nxt.detector_mode;
      result.spectrum_select    = nxt.spectrum;
      result.agc_enable         = nxt.agc;
      result.timing_enable      = nxt.timing;
      result.equalizer_mode     = nxt.equalizer;
      result.rate_detector_mode = nxt.rate_det;
      result.symbol_mode        = nxt.symbol_mode;
      result.line_rate          = nxt.line_rate;
      result.rate_found         = nxt.rate_found;
      result.actions            = act;
   end

endmodule

`default_nettype wire

FILE: rtl/modem_call_receiver_training_sequencer_core.sv
// caller receive training sequencer for a V.32bis-style handshake.
// one req word per symbol block carries detector, handoff, idle, retrain and
// equalizer-init flags plus the detected rate code; one rsp word comes back
// per req word with phase, detector/equalizer/rate-detector modes, agc and
// timing enables, symbol mode, line rate, rate-found flag and action strobes.
// latency: the rsp word is valid the cycle after its req word is taken.
// throughput: one word per cycle while rsp_ready is high; the next-state
// logic is a single pass between the state registers and the rsp output register.
// req_ready is high whenever the output register is empty or being drained,
// so a stalled receiver (rsp_ready low) holds rsp_word and stops intake only
// while the output register is full.
// csr port: write enable, index and 16-bit data, written any cycle without
// wait; registers keep their value across retrain.
// reset (synchronous, active high) puts the sequencer in the answer tone
// phase with all controls off, restores csr defaults and empties the output.
// depends on mcrts_pkg, mcrts_csr and mcrts_step
`default_nettype none

module modem_call_receiver_training_sequencer_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire mcrts_pkg::req_word_type               req_word,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output mcrts_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                  csr_wr_en,
   input  wire logic [mcrts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mcrts_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   mcrts_pkg::csr_type        csr;
   mcrts_pkg::ctrl_state_type state_ff;
   mcrts_pkg::ctrl_state_type state_in;
   logic [COUNT_WIDTH-1:0]    count_ff;
   logic [COUNT_WIDTH-1:0]    count_in;
   mcrts_pkg::rsp_word_type   rsp_ff;
   mcrts_pkg::rsp_word_type   rsp_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      accept;

   mcrts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   mcrts_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cur       (state_ff),
      .count_cur (count_ff),
      .word      (req_word),
      .csr       (csr),
      .nxt       (state_in),
      .count_nxt (count_in),
      .result    (rsp_in)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcrts_pkg::STATE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no response");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("intake stalled with empty output register");

   a_rate_found_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.rate_found |-> (state_ff.phase == mcrts_pkg::PH_E
         || state_ff.phase == mcrts_pkg::PH_B1 || state_ff.phase == mcrts_pkg::PH_START
         || state_ff.phase == mcrts_pkg::PH_DATA))
      else $error("rate found outside rate or data phases");

   a_line_rate_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff.line_rate != mcrts_pkg::RATE_NONE) |-> (state_ff.phase == mcrts_pkg::PH_B1
         || state_ff.phase == mcrts_pkg::PH_START || state_ff.phase == mcrts_pkg::PH_DATA))
      else $error("line rate set before B1");

endmodule

`default_nettype wire
